// File: rtl/dltq_pkg.sv
// Shared types and codes for the delta-list timer queue.
// No dependencies; imported by dltq_cell, delta_list_timer_queue and the testbench.
`default_nettype none

package dltq_pkg;

  localparam int ID_W        = 8;
  localparam int IN_DELAY_W  = 24;
  localparam int OUT_DELTA_W = 24;
  localparam int STATUS_W    = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUP       = 2'd3
  } status_t;

  // Where the walking token stands relative to the edit point.
  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_NEXT,
    PH_AFTER
  } phase_t;

  // What a cell does on commit.
  typedef enum logic [1:0] {
    PL_KEEP,
    PL_LOAD,
    PL_LEFT,
    PL_RIGHT
  } plan_t;

  typedef struct packed {
    logic   valid;
    phase_t phase;
    logic   hit;
  } tok_ctl_t;

endpackage

`default_nettype wire

// File: rtl/delta_list_timer_queue.sv
// Delta-list timer queue: a row of dltq_cell slots plus the command control.
// An accepted command's token passes the launch register, then each cell's token
// register, walking the chain one slot per cycle; the commit is made as it leaves the
// last cell, and the registered result strobe rises as busy drops. Synchronous
// active-low reset empties the list. Results cannot be stalled.
// Depends on dltq_pkg and dltq_cell.
`default_nettype none

module delta_list_timer_queue #(
  parameter int MAX_TIMERS = 16,
  parameter int TIME_BITS  = 24,
  localparam int CNT_W     = $clog2(MAX_TIMERS + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // command transaction
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_command,
  input  wire logic [dltq_pkg::ID_W-1:0]        in_timer_id,
  input  wire logic [dltq_pkg::IN_DELAY_W-1:0]  in_delay_ms,
  input  wire logic                             in_periodic,
  // result transaction, one cycle strobe
  output logic                                  out_strobe,
  output logic [dltq_pkg::STATUS_W-1:0]         out_status,
  output logic [CNT_W-1:0]                      out_entry_count,
  output logic                                  out_head_valid,
  output logic [dltq_pkg::ID_W-1:0]             out_head_id,
  output logic [dltq_pkg::OUT_DELTA_W-1:0]      out_head_delta
);
  import dltq_pkg::*;

  localparam int N = MAX_TIMERS;

  // held command fields, broadcast to every cell during the walk
  logic                 cmd_r;
  logic [ID_W-1:0]      id_r;
  logic [TIME_BITS-1:0] delay_r;
  logic                 per_r;

  logic                 busy_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 strobe_r;
  status_t              status_r, status_nxt;

  // token launch stage in front of cell 0
  tok_ctl_t             launch_r;
  logic [TIME_BITS-1:0] launch_rem_r;

  logic                 accept;
  logic                 walk_done;
  logic                 commit;
  logic [31:0]          delay_ext;
  logic [31:0]          head_ext;

  tok_ctl_t             tok_c [N];
  logic [TIME_BITS-1:0] tok_rem [N];
  logic                 c_valid [N];
  logic [ID_W-1:0]      c_id [N];
  logic [TIME_BITS-1:0] c_delta [N];
  logic [TIME_BITS-1:0] c_adj [N];
  logic [TIME_BITS-1:0] c_reload [N];
  logic                 c_per [N];

  assign accept    = start && !busy_r;
  assign delay_ext = 32'(in_delay_ms);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      id_r    <= in_timer_id;
      delay_r <= delay_ext[TIME_BITS-1:0];
      per_r   <= in_periodic;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= '{valid: 1'b0, phase: PH_SEARCH, hit: 1'b0};
    end else begin
      launch_r <= '{valid: accept, phase: PH_SEARCH, hit: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) launch_rem_r <= delay_ext[TIME_BITS-1:0];
  end

  // the cell chain; the token leaves the last cell when the walk is over
  for (genvar i = 0; i < N; i++) begin : g_cell
    tok_ctl_t             t_in;
    logic [TIME_BITS-1:0] r_in;
    logic                 lv, rv, lp, rp;
    logic [ID_W-1:0]      lid, rid;
    logic [TIME_BITS-1:0] la, ra, lr, rr;

    if (i == 0) begin : g_first
      assign t_in = launch_r;
      assign r_in = launch_rem_r;
      assign lv   = 1'b0;
      assign lid  = '0;
      assign la   = '0;
      assign lr   = '0;
      assign lp   = 1'b0;
    end else begin : g_mid
      assign t_in = tok_c[i-1];
      assign r_in = tok_rem[i-1];
      assign lv   = c_valid[i-1];
      assign lid  = c_id[i-1];
      assign la   = c_adj[i-1];
      assign lr   = c_reload[i-1];
      assign lp   = c_per[i-1];
    end

    if (i == N - 1) begin : g_last
      assign rv  = 1'b0;
      assign rid = '0;
      assign ra  = '0;
      assign rr  = '0;
      assign rp  = 1'b0;
    end else begin : g_right
      assign rv  = c_valid[i+1];
      assign rid = c_id[i+1];
      assign ra  = c_adj[i+1];
      assign rr  = c_reload[i+1];
      assign rp  = c_per[i+1];
    end

    dltq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_in     (t_in),
      .rem_in     (r_in),
      .tok_out    (tok_c[i]),
      .rem_out    (tok_rem[i]),
      .cmd        (cmd_r),
      .cmd_id     (id_r),
      .commit     (commit),
      .new_delta  (tok_rem[N-1]),
      .new_reload (delay_r),
      .new_per    (per_r),
      .l_valid    (lv),
      .l_id       (lid),
      .l_adj      (la),
      .l_reload   (lr),
      .l_per      (lp),
      .r_valid    (rv),
      .r_id       (rid),
      .r_adj      (ra),
      .r_reload   (rr),
      .r_per      (rp),
      .valid      (c_valid[i]),
      .id         (c_id[i]),
      .delta      (c_delta[i]),
      .adj        (c_adj[i]),
      .reload     (c_reload[i]),
      .per        (c_per[i])
    );
  end

  // end of walk: the token has seen every slot, decide and commit
  assign walk_done = tok_c[N-1].valid;

  always_comb begin
    if (cmd_r == CMD_INSERT) begin
      // duplicate check wins over full
      if (tok_c[N-1].hit)                       status_nxt = ST_DUP;
      else if (count_r == CNT_W'(MAX_TIMERS))   status_nxt = ST_FULL;
      else                                      status_nxt = ST_OK;
    end else begin
      status_nxt = tok_c[N-1].hit ? ST_OK : ST_NOT_FOUND;
    end
  end

  assign commit = walk_done && (status_nxt == ST_OK);

  always_comb begin
    count_nxt = count_r;
    if (commit) begin
      if (cmd_r == CMD_INSERT) count_nxt = CNT_W'(count_r + 1'b1);
      else                     count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      count_r  <= '0;
      strobe_r <= 1'b0;
      status_r <= ST_OK;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= walk_done;
      if (accept)         busy_r <= 1'b1;
      else if (walk_done) busy_r <= 1'b0;
      if (walk_done) status_r <= status_nxt;
    end
  end

  // head fields come straight from slot 0, already updated by the commit
  assign head_ext        = 32'(c_delta[0]);
  assign busy            = busy_r;
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_count = count_r;
  assign out_head_valid  = c_valid[0];
  assign out_head_id     = c_valid[0] ? c_id[0] : '0;
  assign out_head_delta  = c_valid[0] ? head_ext[OUT_DELTA_W-1:0] : '0;

`ifndef SYNTHESIS
  a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while a walk is running");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TIMERS))
    else $error("entry count exceeds capacity");

  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_head_valid == (count_r != '0))
    else $error("head slot validity disagrees with entry count");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_walk_ends_once: assert property (@(posedge clk) disable iff (!rst_n)
    walk_done |=> !walk_done)
    else $error("token left the chain twice for one command");
`endif

endmodule

`default_nettype wire

// File: rtl/dltq_cell.sv
// One slot of the timer chain: entry storage, per-walk edit plan, token stage.
// Depends on dltq_pkg.
`default_nettype none

module dltq_cell #(
  parameter int TIME_BITS = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // token from the left neighbor
  input  wire dltq_pkg::tok_ctl_t        tok_in,
  input  wire logic [TIME_BITS-1:0]      rem_in,
  output dltq_pkg::tok_ctl_t             tok_out,
  output logic [TIME_BITS-1:0]           rem_out,
  // current transaction, broadcast
  input  wire logic                      cmd,
  input  wire logic [dltq_pkg::ID_W-1:0] cmd_id,
  input  wire logic                      commit,
  input  wire logic [TIME_BITS-1:0]      new_delta,
  input  wire logic [TIME_BITS-1:0]      new_reload,
  input  wire logic                      new_per,
  // neighbors
  input  wire logic                      l_valid,
  input  wire logic [dltq_pkg::ID_W-1:0] l_id,
  input  wire logic [TIME_BITS-1:0]      l_adj,
  input  wire logic [TIME_BITS-1:0]      l_reload,
  input  wire logic                      l_per,
  input  wire logic                      r_valid,
  input  wire logic [dltq_pkg::ID_W-1:0] r_id,
  input  wire logic [TIME_BITS-1:0]      r_adj,
  input  wire logic [TIME_BITS-1:0]      r_reload,
  input  wire logic                      r_per,
  // own entry
  output logic                           valid,
  output logic [dltq_pkg::ID_W-1:0]      id,
  output logic [TIME_BITS-1:0]           delta,
  output logic [TIME_BITS-1:0]           adj,
  output logic [TIME_BITS-1:0]           reload,
  output logic                           per
);
  import dltq_pkg::*;

  logic                 valid_r;
  logic [ID_W-1:0]      id_r;
  logic [TIME_BITS-1:0] delta_r;
  logic [TIME_BITS-1:0] reload_r;
  logic                 per_r;
  plan_t                plan_r, plan_nxt;
  logic [TIME_BITS-1:0] adj_r, adj_nxt;
  tok_ctl_t             tok_r, tok_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic                 match;

  assign match = valid_r && (id_r == cmd_id);

  always_comb begin
    plan_nxt      = PL_KEEP;
    adj_nxt       = delta_r;
    rem_nxt       = rem_in;
    tok_nxt       = tok_in;
    tok_nxt.hit   = tok_in.hit | match;
    if (cmd == CMD_INSERT) begin
      unique case (tok_in.phase)
        PH_SEARCH: begin
          if (!valid_r) begin
            plan_nxt      = PL_LOAD;
            tok_nxt.phase = PH_AFTER;
          end else if (rem_in > delta_r) begin
            rem_nxt = TIME_BITS'(rem_in - delta_r);
          end else if (rem_in == delta_r) begin
            rem_nxt       = '0;
            tok_nxt.phase = PH_NEXT;
          end else begin
            plan_nxt      = PL_LOAD;
            adj_nxt       = TIME_BITS'(delta_r - rem_in);
            tok_nxt.phase = PH_AFTER;
          end
        end
        PH_NEXT: begin
          plan_nxt      = PL_LOAD;
          tok_nxt.phase = PH_AFTER;
        end
        PH_AFTER: plan_nxt = PL_LEFT;
        default:  plan_nxt = PL_KEEP;
      endcase
    end else begin
      unique case (tok_in.phase)
        PH_SEARCH: begin
          if (match) begin
            plan_nxt      = PL_RIGHT;
            rem_nxt       = delta_r;
            tok_nxt.phase = PH_NEXT;
          end
        end
        PH_NEXT: begin
          // successor absorbs the removed delta
          plan_nxt      = PL_RIGHT;
          adj_nxt       = TIME_BITS'(delta_r + rem_in);
          tok_nxt.phase = PH_AFTER;
        end
        PH_AFTER: plan_nxt = PL_RIGHT;
        default:  plan_nxt = PL_KEEP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '{valid: 1'b0, phase: PH_SEARCH, hit: 1'b0};
      plan_r <= PL_KEEP;
    end else begin
      tok_r.valid <= tok_in.valid;
      if (tok_in.valid) begin
        tok_r.phase <= tok_nxt.phase;
        tok_r.hit   <= tok_nxt.hit;
        plan_r      <= plan_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      rem_r <= rem_nxt;
      adj_r <= adj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (commit) begin
      unique case (plan_r)
        PL_KEEP:  valid_r <= valid_r;
        PL_LOAD:  valid_r <= 1'b1;
        PL_LEFT:  valid_r <= l_valid;
        PL_RIGHT: valid_r <= r_valid;
        default:  valid_r <= valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      unique case (plan_r)
        PL_KEEP: begin
          delta_r <= adj_r;
        end
        PL_LOAD: begin
          id_r     <= cmd_id;
          delta_r  <= new_delta;
          reload_r <= new_reload;
          per_r    <= new_per;
        end
        PL_LEFT: begin
          id_r     <= l_id;
          delta_r  <= l_adj;
          reload_r <= l_reload;
          per_r    <= l_per;
        end
        PL_RIGHT: begin
          id_r     <= r_id;
          delta_r  <= r_adj;
          reload_r <= r_reload;
          per_r    <= r_per;
        end
        default: delta_r <= delta_r;
      endcase
    end
  end

  assign tok_out = tok_r;
  assign rem_out = rem_r;
  assign valid   = valid_r;
  assign id      = id_r;
  assign delta   = delta_r;
  assign adj     = adj_r;
  assign reload  = reload_r;
  assign per     = per_r;

endmodule

`default_nettype wire

// File: tb/sv/delta_list_timer_queue_checker.sv
// Checker for the delta-list timer queue: watches both transaction channels,
// keeps its own delta list and compares every result. Depends on dltq_pkg.
`default_nettype none

module delta_list_timer_queue_checker
  import dltq_pkg::*;
#(
  parameter int MAX_TIMERS = 16,
  parameter int TIME_BITS  = 24,
  localparam int CNT_W     = $clog2(MAX_TIMERS + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic                   busy,
  input  wire logic                   in_command,
  input  wire logic [ID_W-1:0]        in_timer_id,
  input  wire logic [IN_DELAY_W-1:0]  in_delay_ms,
  input  wire logic                   in_periodic,
  input  wire logic                   out_strobe,
  input  wire logic [STATUS_W-1:0]    out_status,
  input  wire logic [CNT_W-1:0]       out_entry_count,
  input  wire logic                   out_head_valid,
  input  wire logic [ID_W-1:0]        out_head_id,
  input  wire logic [OUT_DELTA_W-1:0] out_head_delta,
  output int                          mismatch_count,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                status;
    logic [CNT_W-1:0]       entry_count;
    logic                   head_valid;
    logic [ID_W-1:0]        head_id;
    logic [OUT_DELTA_W-1:0] head_delta;
  } timer_reply_t;

  // Shadow delta list, slot 0 is the head.
  logic [ID_W-1:0]      list_id       [MAX_TIMERS];
  logic [TIME_BITS-1:0] list_delta    [MAX_TIMERS];
  logic [TIME_BITS-1:0] list_reload   [MAX_TIMERS];
  logic                 list_periodic [MAX_TIMERS];
  int                   list_len;

  timer_reply_t predicted_replies [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    list_len       = 0;
  end

  function automatic timer_reply_t apply_timer_command(input logic cmd,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [IN_DELAY_W-1:0] delay,
                                                       input logic per);
    timer_reply_t         reply;
    logic [TIME_BITS-1:0] remaining;
    int                   found;
    int                   pos;
    found = -1;
    for (int i = 0; i < list_len; i++) begin
      if (found < 0 && list_id[i] == id) found = i;
    end
    reply.status = ST_OK;
    if (cmd == CMD_INSERT) begin
      if (found >= 0) begin
        reply.status = ST_DUP;
      end else if (list_len >= MAX_TIMERS) begin
        reply.status = ST_FULL;
      end else begin
        remaining = delay[TIME_BITS-1:0];
        pos       = list_len;
        // walk the list; tie goes after the tied entry with delta 0
        for (int i = 0; i < list_len; i++) begin
          if (remaining > list_delta[i]) begin
            remaining = remaining - list_delta[i];
          end else if (remaining == list_delta[i]) begin
            remaining = '0;
            pos       = i + 1;
            break;
          end else begin
            list_delta[i] = list_delta[i] - remaining;
            pos           = i;
            break;
          end
        end
        for (int i = list_len; i > pos; i--) begin
          list_id[i]       = list_id[i-1];
          list_delta[i]    = list_delta[i-1];
          list_reload[i]   = list_reload[i-1];
          list_periodic[i] = list_periodic[i-1];
        end
        list_id[pos]       = id;
        list_delta[pos]    = remaining;
        list_reload[pos]   = delay[TIME_BITS-1:0];
        list_periodic[pos] = per;
        list_len++;
      end
    end else begin
      if (found < 0) begin
        reply.status = ST_NOT_FOUND;
      end else begin
        // successor inherits the removed delta
        if (found + 1 < list_len) list_delta[found+1] = list_delta[found+1] + list_delta[found];
        for (int i = found; i + 1 < list_len; i++) begin
          list_id[i]       = list_id[i+1];
          list_delta[i]    = list_delta[i+1];
          list_reload[i]   = list_reload[i+1];
          list_periodic[i] = list_periodic[i+1];
        end
        list_len--;
      end
    end
    reply.entry_count = CNT_W'(list_len);
    reply.head_valid  = (list_len > 0);
    reply.head_id     = (list_len > 0) ? list_id[0] : '0;
    reply.head_delta  = (list_len > 0) ? OUT_DELTA_W'(list_delta[0]) : '0;
    return reply;
  endfunction

  task automatic check_field(input string field, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, field, expected, actual);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    timer_reply_t expected;
    if (!rst_n) begin
      list_len = 0;
      for (int i = 0; i < MAX_TIMERS; i++) begin
        list_id[i]       = '0;
        list_delta[i]    = '0;
        list_reload[i]   = '0;
        list_periodic[i] = 1'b0;
      end
      predicted_replies.delete();
    end else begin
      // result first: a new command may be taken on the same edge
      if (out_strobe) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d count %0d head %0d/%0d",
                   $time, out_status, out_entry_count, out_head_id, out_head_delta);
          mismatch_count++;
        end else begin
          expected = predicted_replies.pop_front();
          check_field("status", 32'(expected.status), 32'(out_status));
          check_field("entry_count", 32'(expected.entry_count), 32'(out_entry_count));
          check_field("head_valid", 32'(expected.head_valid), 32'(out_head_valid));
          check_field("head_id", 32'(expected.head_id), 32'(out_head_id));
          check_field("head_delta", 32'(expected.head_delta), 32'(out_head_delta));
        end
      end
      if (start && !busy) begin
        predicted_replies.push_back(apply_timer_command(in_command, in_timer_id,
                                                        in_delay_ms, in_periodic));
      end
    end
    outstanding <= predicted_replies.size();
  end

endmodule

`default_nettype wire

// File: tb/sv/delta_list_timer_queue_tb.sv
// Top of the timer queue testbench: clock, reset, command stimulus and verdict.
// Depends on dltq_pkg, delta_list_timer_queue and delta_list_timer_queue_checker.
`default_nettype none

module delta_list_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dltq_pkg::*;

  localparam int MAX_TIMERS = 16;
  localparam int TIME_BITS  = 24;
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
  // Wait after the last result, with margin over one command's walk.
  localparam int DRAIN_CYCLES = MAX_TIMERS + 8;
  // Per-phase chance (percent) that the sender idles before a command.
  localparam int N_PHASES = 4;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int IDLE_PCT [N_PHASES] = '{0, 48, 17, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // All inputs start at known values.
  logic                  start       = 1'b0;
  logic                  in_command  = CMD_INSERT;
  logic [ID_W-1:0]       in_timer_id = '0;
  logic [IN_DELAY_W-1:0] in_delay_ms = '0;
  logic                  in_periodic = 1'b0;

  logic                   busy;
  logic                   out_strobe;
  logic [STATUS_W-1:0]    out_status;
  logic [CNT_W-1:0]       out_entry_count;
  logic                   out_head_valid;
  logic [ID_W-1:0]        out_head_id;
  logic [OUT_DELTA_W-1:0] out_head_delta;

  int mismatch_count;
  int outstanding;
  int idle_pct = 0;

  delta_list_timer_queue #(
    .MAX_TIMERS(MAX_TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_timer_id    (in_timer_id),
    .in_delay_ms    (in_delay_ms),
    .in_periodic    (in_periodic),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_entry_count(out_entry_count),
    .out_head_valid (out_head_valid),
    .out_head_id    (out_head_id),
    .out_head_delta (out_head_delta)
  );

  delta_list_timer_queue_checker #(
    .MAX_TIMERS(MAX_TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_timer_id    (in_timer_id),
    .in_delay_ms    (in_delay_ms),
    .in_periodic    (in_periodic),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_entry_count(out_entry_count),
    .out_head_valid (out_head_valid),
    .out_head_id    (out_head_id),
    .out_head_delta (out_head_delta),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Issue one command transaction. Called at a rising edge (or right after
  // reset); returns at the edge where the command was accepted, with start
  // still high so a back-to-back command keeps it high without a glitch.
  task automatic issue_command(input logic cmd, input logic [ID_W-1:0] id,
                               input logic [IN_DELAY_W-1:0] delay, input logic per);
    int gap;
    // Optional idle stretch: long enough to land on any cycle of the
    // block's walk, or after busy has already dropped.
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, MAX_TIMERS + 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_command  <= cmd;
    in_timer_id <= id;
    in_delay_ms <= delay;
    in_periodic <= per;
    // Accepted at the first edge that sees start high and busy low.
    do @(posedge clk); while (busy);
  endtask

  // Random delay with a bias toward small values so that exact ties,
  // insert-in-front and append paths all come up often.
  function automatic logic [IN_DELAY_W-1:0] pick_delay();
    case ($urandom_range(3))
      0:       return IN_DELAY_W'($urandom_range(0, 7));
      1:       return IN_DELAY_W'($urandom_range(0, 1000));
      2:       return IN_DELAY_W'($urandom);
      default: return {$urandom_range(0, 1) ? 4'hF : 4'h0, 20'($urandom_range(0, 15))};
    endcase
  endfunction

  initial begin : stimulus
    int insert_pct;
    logic [ID_W-1:0] id;
    // Reset held at start, then released once for the whole run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    issue_command(CMD_REMOVE, 8'd7, 24'd0, 1'b0);          // remove from empty list
    issue_command(CMD_INSERT, 8'd0, 24'd0, 1'b0);          // zero delay, lowest id
    issue_command(CMD_INSERT, 8'd255, 24'hFFFFFF, 1'b1);   // max delay, max id
    issue_command(CMD_INSERT, 8'd5, 24'd0, 1'b0);          // tie with head, goes after
    issue_command(CMD_INSERT, 8'd255, 24'd3, 1'b0);        // duplicate id
    issue_command(CMD_INSERT, 8'd9, 24'd1000, 1'b1);       // middle
    issue_command(CMD_INSERT, 8'd10, 24'd400, 1'b0);       // in front, shrinks successor
    issue_command(CMD_INSERT, 8'd11, 24'd1000, 1'b1);      // tie in the middle
    issue_command(CMD_INSERT, 8'd12, 24'hFFFFFF, 1'b0);    // tie with the tail
    issue_command(CMD_INSERT, 8'd13, 24'hAAAAAA, 1'b1);
    issue_command(CMD_INSERT, 8'd14, 24'h555555, 1'b0);
    issue_command(CMD_REMOVE, 8'd0, 24'hFFFFFF, 1'b1);     // head with delta 0
    issue_command(CMD_REMOVE, 8'd5, 24'd0, 1'b0);
    issue_command(CMD_REMOVE, 8'd10, 24'd0, 1'b0);         // head delta folds into next
    issue_command(CMD_REMOVE, 8'd12, 24'd0, 1'b0);         // tail, no successor
    issue_command(CMD_REMOVE, 8'd200, 24'd0, 1'b0);        // unknown id
    issue_command(CMD_REMOVE, 8'd9, 24'd0, 1'b0);          // head entry

    // ---- random part ----
    // Ids mostly from a pool a bit larger than the list, so removes usually
    // hit, inserts often collide, and insert-heavy epochs fill the list.
    insert_pct = 85;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_pct = IDLE_PCT[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          case ($urandom_range(2))
            0:       insert_pct = 85;   // fill toward full
            1:       insert_pct = 50;
            default: insert_pct = 20;   // drain toward empty
          endcase
        end
        if ($urandom_range(7) == 0) id = ID_W'($urandom_range(255));
        else id = ID_W'($urandom_range(0, MAX_TIMERS + 3));
        issue_command(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE, id,
                      pick_delay(), 1'($urandom_range(1)));
      end
    end
    start <= 1'b0;

    // ---- drain and verdict ----
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: about 1400 commands, each with its walk and an optional idle
  // stretch, finish well inside this time limit.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// File: delta_list_timer_queue.f
rtl/dltq_pkg.sv
rtl/dltq_cell.sv
rtl/delta_list_timer_queue.sv
tb/sv/delta_list_timer_queue_checker.sv
tb/sv/delta_list_timer_queue_tb.sv
